@@ hw/rtl/ptw_pkg.sv @@
`default_nettype none

package ptw_pkg;

    // physical address width of the machine, 36 to 52
    localparam int PHYS_BITS = 52;

    localparam int ADDR_W    = 52;
    localparam int VADDR_W   = 48;
    localparam int DATA_W    = 64;
    localparam int LEVELS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = 9;

    // depth of the queue between front and back and of the result queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [ADDR_W-1:0] PHYS_MASK =
        ADDR_W'((64'd1 << PHYS_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] FRAME_4K_MASK = PHYS_MASK & ~ADDR_W'(52'hFFF);
    localparam logic [ADDR_W-1:0] FRAME_2M_MASK = PHYS_MASK & ~ADDR_W'(52'h1FFFFF);
    localparam logic [ADDR_W-1:0] PAE_ROOT_MASK = PHYS_MASK & ~ADDR_W'(52'h1F);

    localparam logic [CFG_IDX_W-1:0] CFG_PAGING_LEVELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TABLE    = 2'd1;

    localparam logic [LEVELS_W-1:0] LEVELS_PAE  = 3'd3;
    localparam logic [LEVELS_W-1:0] LEVELS_LONG = 3'd4;

    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    typedef enum logic {
        OP_TRANSLATE = 1'b0,
        OP_READ_DATA = 1'b1
    } op_t;

    typedef enum logic {
        KIND_READ = 1'b0,
        KIND_DONE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NOT_PRESENT = 2'd1,
        STATUS_UNSUPPORTED = 2'd2
    } status_t;

    // table whose entry is awaited
    typedef enum logic [1:0] {
        LVL_PT   = 2'd0,
        LVL_PD   = 2'd1,
        LVL_PDP  = 2'd2,
        LVL_PML4 = 2'd3
    } level_t;

    // one input beat after classification
    typedef struct packed {
        logic                is_req;
        logic                unsup;
        level_t              start_level;
        logic [VADDR_W-1:0]  vaddr;
        logic [ADDR_W-1:0]   first_addr;
        logic                present;
        logic                big_page;
        logic [ADDR_W-1:0]   base;
    } mid_item_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   read_addr;
        logic [DATA_W-1:0]   mach_addr;
        status_t             status;
    } res_t;

    function automatic logic [ADDR_W-1:0] entry_addr(
        input logic [ADDR_W-1:0] base,
        input logic [IDX_W-1:0]  idx
    );
        return base | ADDR_W'({idx, 3'b000});
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ptw_front.sv @@
`default_nettype none

module ptw_front
    import ptw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 op,
    input  wire logic [VADDR_W-1:0]   virt_addr,
    input  wire logic [DATA_W-1:0]    read_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data,
    output logic                      mid_valid,
    output mid_item_t                 mid_item,
    input  wire logic                 mid_ready
);

    logic [LEVELS_W-1:0] levels_reg;
    logic [ADDR_W-1:0]   root_reg;

    mid_item_t           item_next;
    mid_item_t           mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_CNT_W-1:0]  count_reg;
    logic [Q_CNT_W-1:0]  count_next;
    logic                wr_en;
    logic                rd_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= LEVELS_LONG;
            root_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_PAGING_LEVELS)
                levels_reg <= cfg_data[LEVELS_W-1:0];
            else if (cfg_index == CFG_ROOT_TABLE)
                root_reg <= cfg_data;
        end
    end

    // classify the beat: first read address for a request, entry flags for data
    always_comb
    begin
        item_next.is_req   = (op == OP_TRANSLATE);
        item_next.vaddr    = virt_addr;
        item_next.present  = read_data[PRESENT_BIT];
        item_next.big_page = read_data[LARGE_BIT];
        item_next.base     = read_data[ADDR_W-1:0] & FRAME_4K_MASK;
        item_next.unsup    = (levels_reg < LEVELS_PAE);
        if (levels_reg >= LEVELS_LONG)
        begin
            item_next.start_level = LVL_PML4;
            item_next.first_addr  = entry_addr(root_reg & FRAME_4K_MASK,
                                               virt_addr[47:39]);
        end
        else
        begin
            item_next.start_level = LVL_PDP;
            item_next.first_addr  = entry_addr(root_reg & PAE_ROOT_MASK,
                                               IDX_W'(virt_addr[31:30]));
        end
    end

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign wr_en     = push && !full;
    assign mid_valid = (count_reg != '0);
    assign rd_en     = mid_valid && mid_ready;
    assign mid_item  = mem_reg[rd_ptr_reg];

    assign count_next = count_reg + Q_CNT_W'(wr_en) - Q_CNT_W'(rd_en);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= item_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/ptw_back.sv @@
`default_nettype none

module ptw_back
    import ptw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      mid_valid,
    input  wire mid_item_t mid_item,
    output logic           mid_ready,
    output logic           empty,
    input  wire logic      pop,
    output res_t           res_head
);

    logic               busy_reg;
    logic               busy_next;
    level_t             level_reg;
    level_t             level_next;
    logic [VADDR_W-1:0] vaddr_reg;
    logic [VADDR_W-1:0] vaddr_next;

    logic               take;
    logic               res_push;
    res_t               res;

    res_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               rd_en;

    assign mid_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign take      = mid_valid && mid_ready;

    always_comb
    begin
        busy_next  = busy_reg;
        level_next = level_reg;
        vaddr_next = vaddr_reg;
        res_push   = 1'b0;
        res        = '{kind: KIND_READ, read_addr: '0, mach_addr: '0,
                       status: STATUS_OK};
        if (take)
        begin
            if (mid_item.is_req)
            begin
                if (!busy_reg)
                begin
                    vaddr_next = mid_item.vaddr;
                    res_push   = 1'b1;
                    if (mid_item.unsup)
                    begin
                        res.kind      = KIND_DONE;
                        res.mach_addr = '1;
                        res.status    = STATUS_UNSUPPORTED;
                    end
                    else
                    begin
                        busy_next     = 1'b1;
                        level_next    = mid_item.start_level;
                        res.read_addr = mid_item.first_addr;
                    end
                end
            end
            else if (busy_reg)
            begin
                res_push = 1'b1;
                if (!mid_item.present)
                begin
                    res.kind      = KIND_DONE;
                    res.mach_addr = '1;
                    res.status    = STATUS_NOT_PRESENT;
                    busy_next     = 1'b0;
                    level_next    = LVL_PT;
                end
                else
                begin
                    unique case (level_reg)
                        LVL_PML4:
                        begin
                            level_next    = LVL_PDP;
                            res.read_addr = entry_addr(mid_item.base, vaddr_reg[38:30]);
                        end
                        LVL_PDP:
                        begin
                            level_next    = LVL_PD;
                            res.read_addr = entry_addr(mid_item.base, vaddr_reg[29:21]);
                        end
                        LVL_PD:
                        begin
                            if (mid_item.big_page)
                            begin
                                // 2M page ends the walk here
                                res.kind      = KIND_DONE;
                                res.mach_addr = DATA_W'((mid_item.base & FRAME_2M_MASK)
                                                | ADDR_W'(vaddr_reg[20:0]));
                                busy_next     = 1'b0;
                                level_next    = LVL_PT;
                            end
                            else
                            begin
                                level_next    = LVL_PT;
                                res.read_addr = entry_addr(mid_item.base,
                                                           vaddr_reg[20:12]);
                            end
                        end
                        LVL_PT:
                        begin
                            res.kind      = KIND_DONE;
                            res.mach_addr = DATA_W'(mid_item.base
                                            | ADDR_W'(vaddr_reg[11:0]));
                            busy_next     = 1'b0;
                            level_next    = LVL_PT;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            level_reg <= LVL_PT;
            vaddr_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            level_reg <= level_next;
            vaddr_reg <= vaddr_next;
        end
    end

    // result queue
    assign empty      = (count_reg == '0);
    assign rd_en      = pop && !empty;
    assign res_head   = mem_reg[rd_ptr_reg];
    assign count_next = count_reg + Q_CNT_W'(res_push) - Q_CNT_W'(rd_en);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (res_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            mem_reg[wr_ptr_reg] <= res;
    end

    a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> level_reg == LVL_PT)
        else $error("idle walker holds a nonzero level");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.kind == KIND_DONE) |=> !busy_reg)
        else $error("walker still busy after a finished translation");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.kind == KIND_READ) |=> busy_reg)
        else $error("read request issued without a walk in progress");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

endmodule

`default_nettype wire

@@ hw/rtl/x86_page_table_walker.sv @@
// x86 page table walker for 4-level long mode and 3-level PAE. Each input beat is either a
// translate request or a returned table entry; each gives at most one result beat: a read
// request for the next entry, or a finished translation with status. The block takes one
// beat per cycle on each side unless full or an empty result queue holds it. A beat passes
// a 2-entry classify queue and a 2-entry result queue, and its result is registered in each
// before it reaches the outputs; full rises only when the result queue stays unpopped and
// both queues fill. Configuration writes are always ready and take effect on the next beat.
`default_nettype none

module x86_page_table_walker
    import ptw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 op,
    input  wire logic [VADDR_W-1:0]   virt_addr,
    input  wire logic [DATA_W-1:0]    read_data,
    output logic                      empty,
    input  wire logic                 pop,
    output logic                      kind,
    output logic [ADDR_W-1:0]         read_addr,
    output logic [DATA_W-1:0]         mach_addr,
    output logic [1:0]                status,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data
);

    logic      mid_valid;
    logic      mid_ready;
    mid_item_t mid_item;
    res_t      res_head;

    ptw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .virt_addr (virt_addr),
        .read_data (read_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mid_valid (mid_valid),
        .mid_item  (mid_item),
        .mid_ready (mid_ready)
    );

    ptw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (mid_valid),
        .mid_item  (mid_item),
        .mid_ready (mid_ready),
        .empty     (empty),
        .pop       (pop),
        .res_head  (res_head)
    );

    assign kind      = res_head.kind;
    assign read_addr = res_head.read_addr;
    assign mach_addr = res_head.mach_addr;
    assign status    = res_head.status;

endmodule

`default_nettype wire

@@ tb/sv/ptw_walk_checker.sv @@
`timescale 1ns / 1ps

module ptw_walk_checker
    import ptw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic                 full,
    input  wire logic                 op,
    input  wire logic [VADDR_W-1:0]   virt_addr,
    input  wire logic [DATA_W-1:0]    read_data,
    input  wire logic                 empty,
    input  wire logic                 pop,
    input  wire logic                 kind,
    input  wire logic [ADDR_W-1:0]    read_addr,
    input  wire logic [DATA_W-1:0]    mach_addr,
    input  wire logic [1:0]           status,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data,
    output int                        fail_count,
    output int                        outstanding,
    output int                        checked_count
);

    localparam int REPORT_LIMIT = 10;

    localparam logic [ADDR_W-1:0] PHYS_LIM       = ADDR_W'((64'd1 << PHYS_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] TBL_BASE_MASK  = PHYS_LIM & 52'hF_FFFF_FFFF_F000;
    localparam logic [ADDR_W-1:0] HUGE_BASE_MASK = PHYS_LIM & 52'hF_FFFF_FFE0_0000;
    localparam logic [ADDR_W-1:0] PAE_CR3_MASK   = PHYS_LIM & 52'hF_FFFF_FFFF_FFE0;
    localparam logic [DATA_W-1:0] FAULT_ADDR     = '1;

    // register copies and walk state
    logic [LEVELS_W-1:0] levels_reg = LEVELS_LONG;
    logic [ADDR_W-1:0]   root_reg   = '0;
    logic                walking    = 1'b0;
    level_t              awaited    = LVL_PT;
    logic [VADDR_W-1:0]  held_va    = '0;

    res_t due_results[$];
    int   errors  = 0;
    int   checked = 0;

    function automatic res_t read_beat(input logic [ADDR_W-1:0] addr);
        res_t r;
        r.kind      = KIND_READ;
        r.read_addr = addr;
        r.mach_addr = '0;
        r.status    = STATUS_OK;
        return r;
    endfunction

    function automatic res_t done_beat(input logic [DATA_W-1:0] maddr, input status_t st);
        res_t r;
        r.kind      = KIND_DONE;
        r.read_addr = '0;
        r.mach_addr = maddr;
        r.status    = st;
        return r;
    endfunction

    task automatic finish_walk(input logic [DATA_W-1:0] maddr, input status_t st);
        due_results.push_back(done_beat(maddr, st));
        walking = 1'b0;
        awaited = LVL_PT;
    endtask

    task automatic advance_walk(
        input logic               is_entry,
        input logic [VADDR_W-1:0] va,
        input logic [DATA_W-1:0]  entry
    );
        logic [ADDR_W-1:0] base;
        base = entry[ADDR_W-1:0] & TBL_BASE_MASK;
        if (!is_entry) begin
            if (walking)
                return;
            held_va = va;
            if (levels_reg < LEVELS_PAE) begin
                finish_walk(FAULT_ADDR, STATUS_UNSUPPORTED);
            end
            else if (levels_reg >= LEVELS_LONG) begin
                walking = 1'b1;
                awaited = LVL_PML4;
                due_results.push_back(read_beat((root_reg & TBL_BASE_MASK)
                                                | ADDR_W'({va[47:39], 3'b000})));
            end
            else begin
                // pae root is 32-byte aligned, 4-entry pdp table
                walking = 1'b1;
                awaited = LVL_PDP;
                due_results.push_back(read_beat((root_reg & PAE_CR3_MASK)
                                                | ADDR_W'({va[31:30], 3'b000})));
            end
            return;
        end
        if (!walking)
            return;
        if (!entry[PRESENT_BIT]) begin
            finish_walk(FAULT_ADDR, STATUS_NOT_PRESENT);
            return;
        end
        case (awaited)
            LVL_PML4: begin
                awaited = LVL_PDP;
                due_results.push_back(read_beat(base | ADDR_W'({held_va[38:30], 3'b000})));
            end
            LVL_PDP: begin
                awaited = LVL_PD;
                due_results.push_back(read_beat(base | ADDR_W'({held_va[29:21], 3'b000})));
            end
            LVL_PD: begin
                if (entry[LARGE_BIT]) begin
                    finish_walk(DATA_W'((entry[ADDR_W-1:0] & HUGE_BASE_MASK)
                                        | ADDR_W'(held_va[20:0])), STATUS_OK);
                end
                else begin
                    awaited = LVL_PT;
                    due_results.push_back(read_beat(base
                                                    | ADDR_W'({held_va[20:12], 3'b000})));
                end
            end
            default: begin
                finish_walk(DATA_W'(base | ADDR_W'(held_va[11:0])), STATUS_OK);
            end
        endcase
    endtask

    task automatic check_result();
        res_t want;
        if (due_results.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("[%0t] unexpected result beat: kind=%0d read_addr=%h mach_addr=%h status=%0d",
                         $time, kind, read_addr, mach_addr, status);
            return;
        end
        want = due_results.pop_front();
        checked++;
        if (kind !== want.kind || read_addr !== want.read_addr
            || mach_addr !== want.mach_addr || status !== want.status) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
                $display("[%0t] result mismatch", $time);
                $display("    expected kind=%0d read_addr=%h mach_addr=%h status=%0d",
                         want.kind, want.read_addr, want.mach_addr, want.status);
                $display("    actual   kind=%0d read_addr=%h mach_addr=%h status=%0d",
                         kind, read_addr, mach_addr, status);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            levels_reg = LEVELS_LONG;
            root_reg   = '0;
            walking    = 1'b0;
            awaited    = LVL_PT;
            held_va    = '0;
            due_results.delete();
            outstanding <= 0;
            fail_count  <= errors;
            checked_count <= checked;
        end
        else begin
            if (pop && !empty)
                check_result();
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PAGING_LEVELS: levels_reg = cfg_data[LEVELS_W-1:0];
                    CFG_ROOT_TABLE:    root_reg   = cfg_data;
                    default: ;
                endcase
            end
            if (push && !full)
                advance_walk(op == OP_READ_DATA, virt_addr, read_data);
            outstanding   <= due_results.size();
            fail_count    <= errors;
            checked_count <= checked;
        end
    end

endmodule

@@ tb/sv/tb_x86_page_table_walker.sv @@
`timescale 1ns / 1ps

module tb_x86_page_table_walker
    import ptw_pkg::*;
;

    localparam int CYCLE_LIMIT   = 500_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int N_PHASES      = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic                 op;
    logic [VADDR_W-1:0]   virt_addr;
    logic [DATA_W-1:0]    read_data;
    logic                 empty;
    logic                 pop;
    logic                 kind;
    logic [ADDR_W-1:0]    read_addr;
    logic [DATA_W-1:0]    mach_addr;
    logic [1:0]           status;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    int fail_count;
    int outstanding;
    int checked_count;

    int          cycle_count = 0;
    int          items_done  = 0;
    int          walks       = 0;
    int          modes       = 0;
    bit          tx_idle_on  = 1'b1;
    bit          rx_idle_on  = 1'b1;
    logic [2:0]  cur_levels  = LEVELS_LONG;

    // level counts per random phase: long, pae, the spare long encodings and unsupported
    logic [2:0] phase_levels [N_PHASES] = '{3'd4, 3'd3, 3'd6, 3'd2, 3'd5,
                                            3'd3, 3'd7, 3'd1, 3'd0, 3'd4};
    int         phase_quota  [N_PHASES] = '{230, 230, 200, 60, 200,
                                            230, 200, 60, 60, 330};

    x86_page_table_walker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .virt_addr (virt_addr),
        .read_data (read_data),
        .empty     (empty),
        .pop       (pop),
        .kind      (kind),
        .read_addr (read_addr),
        .mach_addr (mach_addr),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ptw_walk_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .op            (op),
        .virt_addr     (virt_addr),
        .read_data     (read_data),
        .empty         (empty),
        .pop           (pop),
        .kind          (kind),
        .read_addr     (read_addr),
        .mach_addr     (mach_addr),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [VADDR_W-1:0] pick_vaddr();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return VADDR_W'(rand_word());
        endcase
    endfunction

    task automatic send_beat(
        input op_t                o,
        input logic [VADDR_W-1:0] va,
        input logic [DATA_W-1:0]  rd,
        input bit                 counts
    );
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        push      <= 1'b1;
        op        <= o;
        virt_addr <= va;
        read_data <= rd;
        @(posedge clk);
        while (full) @(posedge clk);
        if (counts)
            items_done++;
    endtask

    // lets every due result drain, plus the pipeline depth for beats that give none
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic [2:0] lv, input logic [ADDR_W-1:0] root);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PAGING_LEVELS;
        cfg_data  <= {49'(rand_word()), lv};
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= CFG_ROOT_TABLE;
        cfg_data  <= root;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_levels = lv;
        modes++;
    endtask

    // one translation: entries are all present up to fail_at, large page at the pd step
    task automatic do_walk(
        input logic [VADDR_W-1:0] va,
        input int                 fail_at,
        input bit                 big_page,
        input bit                 plain,
        input int                 noise_at
    );
        int          steps;
        int          i;
        logic [63:0] entry;
        send_beat(OP_TRANSLATE, va, rand_word(), 1'b1);
        walks++;
        if (cur_levels < LEVELS_PAE)
            return;
        steps = (cur_levels >= LEVELS_LONG) ? 4 : 3;
        for (i = 0; i < steps; i++) begin
            entry = plain ? '1 : rand_word();
            entry[PRESENT_BIT] = (i != fail_at);
            if (plain && i == fail_at)
                entry = '0;
            if (i == steps - 2)
                entry[LARGE_BIT] = big_page;
            // translate request while the walk is running, dropped by the block
            if (i == noise_at)
                send_beat(OP_TRANSLATE, pick_vaddr(), rand_word(), 1'b0);
            send_beat(OP_READ_DATA, pick_vaddr(), entry, 1'b1);
            if (i == fail_at || (i == steps - 2 && big_page))
                break;
        end
    endtask

    initial
    begin
        int p;
        int start;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        pop       <= 1'b0;
        op        <= OP_TRANSLATE;
        virt_addr <= '0;
        read_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_PAGING_LEVELS;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: long mode, all-ones root
        set_mode(LEVELS_LONG, '1);
        send_beat(OP_READ_DATA, '1, '1, 1'b0);
        send_beat(OP_READ_DATA, '0, '0, 1'b0);
        do_walk('1, -1, 1'b0, 1'b1, 1);
        do_walk('0, -1, 1'b1, 1'b1, -1);
        do_walk(pick_vaddr(), 0, 1'b0, 1'b1, -1);
        // pae, zero root
        set_mode(LEVELS_PAE, '0);
        do_walk('1, -1, 1'b0, 1'b0, -1);
        do_walk(VADDR_W'(rand_word()), -1, 1'b1, 1'b0, -1);
        // unsupported level counts: stray entry data is dropped
        set_mode(3'd2, ADDR_W'(rand_word()));
        do_walk(pick_vaddr(), -1, 1'b0, 1'b0, -1);
        send_beat(OP_READ_DATA, pick_vaddr(), rand_word(), 1'b0);
        set_mode(3'd0, ADDR_W'(rand_word()));
        do_walk('1, -1, 1'b0, 1'b0, -1);

        for (p = 0; p < N_PHASES; p++) begin
            tx_idle_on = (p != N_PHASES - 1) && (p % 3 != 1);
            rx_idle_on = (p != N_PHASES - 1) && (p % 3 != 2);
            set_mode(phase_levels[p], ADDR_W'(rand_word()));
            start = items_done;
            while (items_done - start < phase_quota[p]) begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(OP_READ_DATA, pick_vaddr(), rand_word(), 1'b0);
                else
                    do_walk(pick_vaddr(),
                            ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : -1,
                            $urandom_range(0, 2) == 0, 1'b0,
                            ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : -1);
            end
        end

        settle();
        $display("ran %0d walks (%0d beats that drive the walk) over %0d paging setups",
                 walks, items_done, modes);
        $display("checked %0d result beats, %0d failures", checked_count, fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // result side: pop mostly high, with stall bursts while enabled
    initial
    begin
        wait (rst_n === 1'b1);
        forever begin
            if (rx_idle_on && $urandom_range(0, 11) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

endmodule
